>>> src/rxcs_pkg.sv
`timescale 1ns / 1ps
// Package for the reversible XOR cascade scrambler: round count, key table and the round function.
// It depends on nothing else; the cascade and the top level use it by scoped names.

package rxcs_pkg;

  localparam int unsigned RoundCount = 32;
  localparam int unsigned RoundIdxW  = $clog2(RoundCount);
  localparam int unsigned WordW      = 32;

  typedef logic [WordW-1:0]     word_t;
  typedef logic [RoundIdxW-1:0] round_idx_t;

  // Two keys per round: the even entry is used when the tested bit is clear,
  // and the odd entry is used when it is set.
  localparam word_t RoundKeys [2*RoundCount] = '{
    32'h0184e0cb, 32'h5ff666ac, 32'h1ed91c34, 32'hfc3cfb81,
    32'hffd14769, 32'h17235246, 32'hc126ce98, 32'h9fceccd6,
    32'hd4118805, 32'h1b9c217a, 32'h5efaca22, 32'ha4fa5272,
    32'hceda18b5, 32'h4d679294, 32'hf8ed82fd, 32'h00f90c31,
    32'h78effad3, 32'hc0302486, 32'h6f2488be, 32'h2f259eb9,
    32'hae18c28c, 32'h33026c62, 32'h30f74370, 32'hfaf23b51,
    32'he988d2ff, 32'hf83ce076, 32'h97164e1c, 32'hccb0d44a,
    32'h294fc698, 32'he6ec0e24, 32'h49053502, 32'h67957e11,
    32'ha3529eb2, 32'hb218da0b, 32'had91efc0, 32'h18b20586,
    32'hd9ee5970, 32'h6d802fcd, 32'hac677d41, 32'h45aadb09,
    32'h25bd7f5a, 32'hf4aa1709, 32'h73729abe, 32'h1955f57a,
    32'hb7ff82fe, 32'hc2fd4555, 32'h651ce530, 32'haca14345,
    32'h3cf1625d, 32'hdc1da391, 32'h45c2c40c, 32'h490ad6f7,
    32'h55d470ca, 32'he45368b2, 32'h466d30fd, 32'hfd23f935,
    32'h03c79884, 32'h7014eaf0, 32'h46f9edee, 32'hdde97ef1,
    32'hca8bd6ef, 32'h593b967c, 32'hc40e2d97, 32'heea252d1
  };

  // One round: the tested bit picks a key, and the key is applied with that
  // bit cleared, so the tested bit passes through unchanged.
  function automatic word_t round_f(word_t w, round_idx_t r);
    word_t  mask;
    logic   pick;
    mask = word_t'(1) << r;
    pick = w[r];
    return w ^ (RoundKeys[{r, pick}] & ~mask);
  endfunction

endpackage

>>> src/rxcs_cascade.sv
`timescale 1ns / 1ps
// Combinational round cascade: forward order for scrambling, reverse order for unscrambling.
// Depends on rxcs_pkg for the key table and the round function.

module rxcs_cascade (
  input  logic           mode_i,
  input  rxcs_pkg::word_t word_i,
  output rxcs_pkg::word_t word_o
);

  rxcs_pkg::word_t fwd [rxcs_pkg::RoundCount+1];
  rxcs_pkg::word_t rev [rxcs_pkg::RoundCount+1];

  assign fwd[0] = word_i;
  assign rev[0] = word_i;

  for (genvar k = 0; k < rxcs_pkg::RoundCount; k++) begin : g_round
    localparam rxcs_pkg::round_idx_t FwdIdx = rxcs_pkg::round_idx_t'(k);
    localparam rxcs_pkg::round_idx_t RevIdx =
      rxcs_pkg::round_idx_t'(rxcs_pkg::RoundCount - 1 - k);
    assign fwd[k+1] = rxcs_pkg::round_f(fwd[k], FwdIdx);
    assign rev[k+1] = rxcs_pkg::round_f(rev[k], RevIdx);
  end

  assign word_o = mode_i ? rev[rxcs_pkg::RoundCount] : fwd[rxcs_pkg::RoundCount];

endmodule

>>> src/reversible_xor_cascade_scrambler.sv
`timescale 1ns / 1ps
// Top level of the reversible XOR cascade scrambler: input register, round cascade, result register.
// Depends on rxcs_pkg and rxcs_cascade.
//
//  Channel   Direction  tdata (low bit up)     tuser
//  s_axis    in         word_in [31:0]         mode (0 scramble, 1 unscramble)
//  m_axis    out        word_out [31:0]        none
//
// A transaction is accepted into the input register and its result moves on into the output
// register once that register is free; one transaction is taken every cycle while
// m_axis_tready stays high. The 32-round cascade lies combinationally between the two
// registers. Reset clears only the valid flags.
// When the output is stalled, the input register still takes one more transaction.

module reversible_xor_cascade_scrambler (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,   // word_in [31:0]
  input  logic                   s_axis_tuser,   // mode [0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [31:0]            m_axis_tdata    // word_out [31:0]
);

  logic            in_vld_q;
  logic            in_mode_q;
  rxcs_pkg::word_t in_word_q;
  logic            out_vld_q;
  rxcs_pkg::word_t out_word_q;
  rxcs_pkg::word_t cascade_word;
  logic            out_free;
  logic            in_adv;
  logic            in_take;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign in_adv        = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  rxcs_cascade u_cascade (
    .mode_i (in_mode_q),
    .word_i (in_word_q),
    .word_o (cascade_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q <= s_axis_tuser;
      in_word_q <= s_axis_tdata;
    end
    if (in_adv) begin
      out_word_q <= cascade_word;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_word_q;

endmodule

>>> src/rxcs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the scrambler: occupancy and stall behaviour over time.
// Attached to reversible_xor_cascade_scrambler by the bind statement at the end of this file.

module rxcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // At most two transactions are ever held inside the block.
  a_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("more than two transactions held");

  // A result is only offered when a transaction is held.
  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !m_axis_tvalid)
    else $error("result offered with nothing held");

  // With both registers full and the output stalled, nothing more is taken.
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while both stages are full and stalled");

  // A stalled result keeps its data.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind reversible_xor_cascade_scrambler rxcs_checker u_rxcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for reversible_xor_cascade_scrambler: streams words in both modes
// and checks each result against a cascade predictor kept here. Needs only the RTL.

module testbench;

  localparam int  StallLimit   = 1000;
  localparam int  DrainCycles  = 8;
  localparam int  ReportLimit  = 10;
  localparam logic ModeScramble   = 1'b0;
  localparam logic ModeUnscramble = 1'b1;

  // Key pairs per round: even entry when the tested bit is clear, odd when it is set.
  localparam logic [31:0] CascadeKeys [64] = '{
    32'h0184e0cb, 32'h5ff666ac, 32'h1ed91c34, 32'hfc3cfb81,
    32'hffd14769, 32'h17235246, 32'hc126ce98, 32'h9fceccd6,
    32'hd4118805, 32'h1b9c217a, 32'h5efaca22, 32'ha4fa5272,
    32'hceda18b5, 32'h4d679294, 32'hf8ed82fd, 32'h00f90c31,
    32'h78effad3, 32'hc0302486, 32'h6f2488be, 32'h2f259eb9,
    32'hae18c28c, 32'h33026c62, 32'h30f74370, 32'hfaf23b51,
    32'he988d2ff, 32'hf83ce076, 32'h97164e1c, 32'hccb0d44a,
    32'h294fc698, 32'he6ec0e24, 32'h49053502, 32'h67957e11,
    32'ha3529eb2, 32'hb218da0b, 32'had91efc0, 32'h18b20586,
    32'hd9ee5970, 32'h6d802fcd, 32'hac677d41, 32'h45aadb09,
    32'h25bd7f5a, 32'hf4aa1709, 32'h73729abe, 32'h1955f57a,
    32'hb7ff82fe, 32'hc2fd4555, 32'h651ce530, 32'haca14345,
    32'h3cf1625d, 32'hdc1da391, 32'h45c2c40c, 32'h490ad6f7,
    32'h55d470ca, 32'he45368b2, 32'h466d30fd, 32'hfd23f935,
    32'h03c79884, 32'h7014eaf0, 32'h46f9edee, 32'hdde97ef1,
    32'hca8bd6ef, 32'h593b967c, 32'hc40e2d97, 32'heea252d1
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic [31:0] expected_words[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int          quiet_cycles   = 0;

  reversible_xor_cascade_scrambler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Scrambling walks the rounds upwards, unscrambling walks them downwards.
  function automatic logic [31:0] cascade_word(input logic mode, input logic [31:0] word);
    logic [31:0] acc;
    logic [31:0] bitmask;
    int          rnd;
    acc = word;
    for (int k = 0; k < 32; k++) begin
      rnd = (mode == ModeUnscramble) ? 31 - k : k;
      bitmask = 32'h1 << rnd;
      acc = acc ^ (CascadeKeys[2 * rnd + int'(acc[rnd])] & ~bitmask);
    end
    return acc;
  endfunction

  // Uniform words half of the time, with sparse and dense patterns mixed in.
  function automatic logic [31:0] random_word();
    logic [31:0] word;
    case ($urandom_range(3))
      0, 1: begin
        word = $urandom;
      end
      2: begin
        word = 32'h1 << $urandom_range(31);
        if ($urandom_range(1) == 1) word = ~word;
      end
      default: begin
        word = {4{8'($urandom)}} & $urandom;
      end
    endcase
    return word;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic send_word(input logic mode, input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_words.push_back(cascade_word(mode, word));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] fwd;
    send_word(ModeScramble,   32'h0000_0000);
    send_word(ModeUnscramble, 32'h0000_0000);
    send_word(ModeScramble,   32'hffff_ffff);
    send_word(ModeUnscramble, 32'hffff_ffff);
    send_word(ModeScramble,   32'h0000_0001);
    send_word(ModeUnscramble, 32'h0000_0001);
    send_word(ModeScramble,   32'h8000_0000);
    send_word(ModeUnscramble, 32'h8000_0000);
    send_word(ModeScramble,   32'haaaa_aaaa);
    send_word(ModeUnscramble, 32'h5555_5555);
    // Round trips: the second word of each pair must come back as the original.
    fwd = cascade_word(ModeScramble, 32'h1234_5678);
    send_word(ModeScramble,   32'h1234_5678);
    send_word(ModeUnscramble, fwd);
    fwd = cascade_word(ModeUnscramble, 32'hdead_beef);
    send_word(ModeUnscramble, 32'hdead_beef);
    send_word(ModeScramble,   fwd);
    if (cascade_word(ModeUnscramble, cascade_word(ModeScramble, 32'h1234_5678)) !==
        32'h1234_5678) begin
      $display("predictor round trip broken");
      mismatch_count++;
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      send_word(logic'($urandom_range(1)), random_word());
    end
  endtask

  // Hold the sender until the pipeline is empty, then restart it with a burst.
  task automatic test_drain_hold();
    for (int n = 0; n < 12; n++) send_word(logic'($urandom_range(1)), random_word());
    wait_drained();
    for (int n = 0; n < 12; n++) send_word(logic'($urandom_range(1)), random_word());
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    logic [31:0] want_word;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected result word_out=%08h", m_axis_tdata);
      end else begin
        want_word = expected_words.pop_front();
        if (m_axis_tdata !== want_word) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("word_out mismatch: expected %08h actual %08h", want_word, m_axis_tdata);
        end
      end
    end
  end

  // Any transaction on either side counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("reversible_xor_cascade_scrambler verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_traffic(23, 61, 390);
    test_drain_hold();
    test_random_traffic(61, 23, 390);
    test_random_traffic(0, 0, 390);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    mismatch_count += expected_words.size();
    if (mismatch_count == 0) begin
      $display("reversible_xor_cascade_scrambler verification clean");
    end else begin
      $display("reversible_xor_cascade_scrambler verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/rxcs_pkg.sv
src/rxcs_cascade.sv
src/reversible_xor_cascade_scrambler.sv
src/rxcs_checker.sv
bench/testbench.sv
